FILE: hw/rtl/vertex_weight_3x3_solver_macros.svh
// ----------------------------------------------------------------------------
// vertex weight solver assertion macros
// concurrent assertion shorthands for the checker
// ----------------------------------------------------------------------------
`ifndef VERTEX_WEIGHT_3X3_SOLVER_MACROS_SVH
`define VERTEX_WEIGHT_3X3_SOLVER_MACROS_SVH

// checked only outside reset
`define VWS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset as well
`define VWS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hw/rtl/vws_pkg.sv
// ----------------------------------------------------------------------------
// vws_pkg
// shared widths, types and helpers of the vertex weight solver
// ----------------------------------------------------------------------------
`default_nettype none

package vws_pkg;

  localparam int CW   = 16;            // coordinate width
  localparam int PW   = 3 * CW;        // packed point width
  localparam int DW   = 3 * CW + 3;    // determinant width
  localparam int XW   = 2 * CW + 1;    // cross product component width
  localparam int WW   = 32;            // weight width
  localparam int FRAC = 16;            // weight fraction bits
  localparam int QB   = 2 * FRAC + 1;  // quotient bits incl. rounding bit
  localparam int AW   = 5;             // apb address width
  localparam int RW   = 64;            // apb data width

  localparam logic [1:0] REG_VERTEX_A = 2'd0;
  localparam logic [1:0] REG_VERTEX_B = 2'd1;
  localparam logic [1:0] REG_VERTEX_C = 2'd2;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic                  valid;
    logic [2:0][DW-1:0]    num;
    logic [DW-1:0]         den;
  } solve_t;

  function automatic coord_t coord(input logic [PW-1:0] pt, input int idx);
    coord = pt[idx*CW +: CW];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/vws_cfg.sv
// ----------------------------------------------------------------------------
// vws_cfg
// apb register file holding the three vertices
// ----------------------------------------------------------------------------
`default_nettype none

module vws_cfg (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [vws_pkg::AW-1:0] paddr,
  input  wire logic [vws_pkg::RW-1:0] pwdata,
  output logic      [vws_pkg::RW-1:0] prdata,
  output logic                        pready,
  output logic      [vws_pkg::PW-1:0] vertex_a_o,
  output logic      [vws_pkg::PW-1:0] vertex_b_o,
  output logic      [vws_pkg::PW-1:0] vertex_c_o
);
  import vws_pkg::*;

  logic [PW-1:0] va_q, vb_q, vc_q;
  logic          wr;
  logic [1:0]    idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign idx    = paddr[4:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= '0;
      vb_q <= '0;
      vc_q <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_VERTEX_A: va_q <= pwdata[PW-1:0];
        REG_VERTEX_B: vb_q <= pwdata[PW-1:0];
        REG_VERTEX_C: vc_q <= pwdata[PW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_VERTEX_A: prdata = RW'(va_q);
      REG_VERTEX_B: prdata = RW'(vb_q);
      REG_VERTEX_C: prdata = RW'(vc_q);
      default:      prdata = '0;
    endcase
  end

  assign vertex_a_o = va_q;
  assign vertex_b_o = vb_q;
  assign vertex_c_o = vc_q;

endmodule

`default_nettype wire

FILE: hw/rtl/vws_det.sv
// ----------------------------------------------------------------------------
// vws_det
// four stage pipeline forming the three numerators and the determinant
// ----------------------------------------------------------------------------
`default_nettype none

module vws_det (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire logic [vws_pkg::PW-1:0] point_i,
  input  wire logic [vws_pkg::PW-1:0] vertex_a_i,
  input  wire logic [vws_pkg::PW-1:0] vertex_b_i,
  input  wire logic [vws_pkg::PW-1:0] vertex_c_i,
  output vws_pkg::solve_t             sol_o
);
  import vws_pkg::*;

  localparam int MW = CW + XW;

  logic [3:0] v_q;

  // stage 1: cross product terms
  logic signed [2*CW-1:0] m1_d [3][6], m1_q [3][6];
  coord_t                 p1_q [3], a1_q [3];
  // stage 2: cross products b x c, c x a, a x b
  logic signed [XW-1:0]   x2_d [3][3], x2_q [3][3];
  coord_t                 p2_q [3], a2_q [3];
  // stage 3: dot product terms, lanes 0..2 numerators, lane 3 determinant
  logic signed [MW-1:0]   m3_d [4][3], m3_q [4][3];
  // stage 4: sums
  logic signed [DW-1:0]   s4_d [4], s4_q [4];

  coord_t a [3], b [3], c [3], p [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a[i] = coord(vertex_a_i, i);
      b[i] = coord(vertex_b_i, i);
      c[i] = coord(vertex_c_i, i);
      p[i] = coord(point_i, i);
    end
    // component i of u x w = u[i+1]*w[i+2] - u[i+2]*w[i+1]
    for (int i = 0; i < 3; i++) begin
      m1_d[0][2*i]   = b[(i+1)%3] * c[(i+2)%3];
      m1_d[0][2*i+1] = b[(i+2)%3] * c[(i+1)%3];
      m1_d[1][2*i]   = c[(i+1)%3] * a[(i+2)%3];
      m1_d[1][2*i+1] = c[(i+2)%3] * a[(i+1)%3];
      m1_d[2][2*i]   = a[(i+1)%3] * b[(i+2)%3];
      m1_d[2][2*i+1] = a[(i+2)%3] * b[(i+1)%3];
    end
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        x2_d[k][i] = XW'(m1_q[k][2*i]) - XW'(m1_q[k][2*i+1]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        m3_d[k][i] = p2_q[i] * x2_q[k][i];
      end
    end
    for (int i = 0; i < 3; i++) begin
      m3_d[3][i] = a2_q[i] * x2_q[0][i];
    end
    for (int k = 0; k < 4; k++) begin
      s4_d[k] = DW'(m3_q[k][0]) + DW'(m3_q[k][1]) + DW'(m3_q[k][2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q <= m1_d;
      p1_q <= p;
      a1_q <= a;
      x2_q <= x2_d;
      p2_q <= p1_q;
      a2_q <= a1_q;
      m3_q <= m3_d;
      s4_q <= s4_d;
    end
  end

  always_comb begin
    sol_o.valid = v_q[3];
    for (int k = 0; k < 3; k++) begin
      sol_o.num[k] = s4_q[k];
    end
    sol_o.den = s4_q[3];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/vws_div.sv
// ----------------------------------------------------------------------------
// vws_div
// pipelined restoring divider, three lanes sharing one divisor,
// one quotient bit per stage, then rounding and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module vws_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  vws_pkg::solve_t                 sol_i,
  output logic                            valid_o,
  output logic [2:0][vws_pkg::WW-1:0]     weight_o,
  output logic                            singular_o,
  output logic                            clipped_o
);
  import vws_pkg::*;

  logic [QB:0]    v_q;
  logic [QB:0]    sing_q;
  logic [DW-1:0]  d_q   [QB+1];
  logic [DW-1:0]  r_q   [3][QB+1];
  logic [FRAC-1:0] lo_q [3][QB+1];
  logic [QB-1:0]  q_q   [3][QB+1];
  logic [QB:0]    neg_q [3];
  logic [QB:0]    sat_q [3];

  // prep stage
  logic [DW-1:0]  n_d [3];
  logic [DW-1:0]  dm_d;
  logic           neg_d [3], sat_d [3];

  always_comb begin
    dm_d = sol_i.den[DW-1] ? DW'(-sol_i.den) : sol_i.den;
    for (int k = 0; k < 3; k++) begin
      n_d[k]   = sol_i.num[k][DW-1] ? DW'(-sol_i.num[k]) : sol_i.num[k];
      neg_d[k] = (sol_i.num[k] != '0) && (sol_i.num[k][DW-1] != sol_i.den[DW-1]);
      sat_d[k] = {{FRAC{1'b0}}, n_d[k]} >= {dm_d, {FRAC{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QB-1:0], sol_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sing_q[0] <= (sol_i.den == '0);
      d_q[0]    <= dm_d;
      for (int k = 0; k < 3; k++) begin
        r_q[k][0]   <= n_d[k] >> FRAC;
        lo_q[k][0]  <= n_d[k][FRAC-1:0];
        q_q[k][0]   <= '0;
        neg_q[k][0] <= neg_d[k];
        sat_q[k][0] <= sat_d[k];
      end
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [DW:0]   t [3];
    logic          ge [3];
    logic [DW-1:0] rn [3];

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        t[k]  = {r_q[k][s], lo_q[k][s][FRAC-1]};
        ge[k] = t[k] >= {1'b0, d_q[s]};
        rn[k] = ge[k] ? DW'(t[k] - {1'b0, d_q[s]}) : DW'(t[k]);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sing_q[s+1] <= sing_q[s];
        d_q[s+1]    <= d_q[s];
        for (int k = 0; k < 3; k++) begin
          r_q[k][s+1]   <= rn[k];
          lo_q[k][s+1]  <= {lo_q[k][s][FRAC-2:0], 1'b0};
          q_q[k][s+1]   <= {q_q[k][s][QB-2:0], ge[k]};
          neg_q[k][s+1] <= neg_q[k][s];
          sat_q[k][s+1] <= sat_q[k][s];
        end
      end
    end
  end

  // rounding and saturation into the output register
  logic [QB-1:0] mag [3], lim [3], magc [3];
  logic          clip [3];
  logic [WW-1:0] w_d [3];
  logic [2:0][WW-1:0] w_q;
  logic          sing_o_q, clip_o_q, v_o_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k]  = QB'(({1'b0, q_q[k][QB]} + (QB+1)'(1)) >> 1);
      lim[k]  = neg_q[k][QB] ? (QB'(1) << (WW-1)) : ((QB'(1) << (WW-1)) - QB'(1));
      clip[k] = sat_q[k][QB] || (mag[k] > lim[k]);
      magc[k] = clip[k] ? lim[k] : mag[k];
      w_d[k]  = neg_q[k][QB] ? WW'(-magc[k][WW-1:0]) : magc[k][WW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_o_q <= 1'b0;
    end else if (en_i) begin
      v_o_q <= v_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sing_o_q <= sing_q[QB];
      clip_o_q <= !sing_q[QB] && (clip[0] || clip[1] || clip[2]);
      for (int k = 0; k < 3; k++) begin
        w_q[k] <= sing_q[QB] ? '0 : w_d[k];
      end
    end
  end

  assign valid_o    = v_o_q;
  assign weight_o   = w_q;
  assign singular_o = sing_o_q;
  assign clipped_o  = clip_o_q;

endmodule

`default_nettype wire

FILE: hw/rtl/vertex_weight_3x3_solver.sv
// ----------------------------------------------------------------------------
// vertex_weight_3x3_solver
// pipeline from input transfer to result (4 determinant stages,
//   one prep stage, 33 divider bit stages, one output register)
// throughput: one query per cycle, set by the one-bit-per-stage divider
// the whole pipeline holds while a result waits at the output
// reset clears all valid bits and the vertex registers to zero
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_weight_3x3_solver (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [vws_pkg::AW-1:0] paddr,
  input  wire logic [vws_pkg::RW-1:0] pwdata,
  output logic      [vws_pkg::RW-1:0] prdata,
  output logic                        pready,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [47:0]            s_axis_tdata,   // query_point
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [95:0]                 m_axis_tdata,   // weight_a, weight_b, weight_c
  output logic [1:0]                  m_axis_tuser    // singular, clipped
);
  import vws_pkg::*;

  logic [PW-1:0]      va, vb, vc;
  logic               en;
  solve_t             sol;
  logic [2:0][WW-1:0] weight;
  logic               singular, clipped;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  vws_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .vertex_a_o(va), .vertex_b_o(vb), .vertex_c_o(vc)
  );

  vws_det u_det (
    .clk_i, .rst_ni,
    .en_i(en),
    .valid_i(s_axis_tvalid),
    .point_i(s_axis_tdata[PW-1:0]),
    .vertex_a_i(va), .vertex_b_i(vb), .vertex_c_i(vc),
    .sol_o(sol)
  );

  vws_div u_div (
    .clk_i, .rst_ni,
    .en_i(en),
    .sol_i(sol),
    .valid_o(m_axis_tvalid),
    .weight_o(weight),
    .singular_o(singular),
    .clipped_o(clipped)
  );

  assign m_axis_tdata = {weight[2], weight[1], weight[0]};
  assign m_axis_tuser = {clipped, singular};

endmodule

`default_nettype wire

FILE: hw/rtl/vws_checker.sv
// ----------------------------------------------------------------------------
// vws_checker
// port level checks of the vertex weight solver
// ----------------------------------------------------------------------------
`default_nettype none

`include "vertex_weight_3x3_solver_macros.svh"

module vws_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [95:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  logic zero_res;
  logic sat_any;

  assign zero_res = (m_axis_tdata == '0) && !m_axis_tuser[1];
  assign sat_any  = m_axis_tdata[31:0] == 32'h7fffffff || m_axis_tdata[31:0] == 32'h80000000 ||
                    m_axis_tdata[63:32] == 32'h7fffffff || m_axis_tdata[63:32] == 32'h80000000 ||
                    m_axis_tdata[95:64] == 32'h7fffffff || m_axis_tdata[95:64] == 32'h80000000;

  `VWS_ASSERT_RST(a_rst_idle, !rst_ni |-> !m_axis_tvalid, "result valid during reset")
  `VWS_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")
  `VWS_ASSERT(a_singular, m_axis_tvalid && m_axis_tuser[0] |-> zero_res, "singular not zero")
  `VWS_ASSERT(a_clip, m_axis_tvalid && m_axis_tuser[1] |-> sat_any, "clipped without sat")

endmodule

bind vertex_weight_3x3_solver vws_checker u_vws_checker (.*);

`default_nettype wire
